// ===== rtl/encoder_hybrid_velocity_assert.svh =====
// assertion macros shared by the checker file
`ifndef ENCODER_HYBRID_VELOCITY_ASSERT_SVH
`define ENCODER_HYBRID_VELOCITY_ASSERT_SVH

// same-cycle implication on the block clock
`define EHV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("encoder_hybrid_velocity: check failed");

// next-cycle implication on the block clock
`define EHV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("encoder_hybrid_velocity: check failed");

`endif

// ===== rtl/ehv_pkg.sv =====
`timescale 1ns / 1ps

package ehv_pkg;

  localparam int CNT_W     = 16;
  localparam int VEL_W     = 32;
  localparam int STALL_W   = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = CNT_W + CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'd1;

  localparam logic [CFG_W-1:0] SCALE_RESET = 32'd25000000;
  localparam logic [VEL_W-1:0] VEL_MAX     = 32'h7fff_ffff;
  localparam logic [VEL_W-1:0] VEL_MIN     = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_SAT,
    ST_FINISH
  } ehv_state_e;

endpackage

// ===== rtl/ehv_divider.sv =====
`timescale 1ns / 1ps

module ehv_divider #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

  logic [CNT_BITS-1:0]   cnt_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] quot_q, quot_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // one restoring step per cycle, msb of the dividend first
  always_comb begin
    rem_sh = {rem_q, quot_q[DIVIDEND_W-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    fits   = ~trial[DIVISOR_W];
    rem_d  = fits ? trial[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    quot_d = {quot_q[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_BITS'(DIVIDEND_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_BITS'(1);
      done_q <= (cnt_q == CNT_BITS'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// ===== rtl/encoder_hybrid_velocity.sv =====
`timescale 1ns / 1ps
// encoder velocity estimate, mixed pulse count and edge timing
// input channel: in_valid_i / in_stall_o carry one word of pulse_count_i and
//   capture_time_i per control-loop request
// output channel: out_valid_o / out_stall_i carry one velocity_o word per request
// configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 stall
//   limit, 1 scale factor); users must write only while idle, it is not enforced
// a request that moves the count passes from acceptance through the multiply,
//   divide, wait, saturate and finish states to the output register; the
//   bit-serial divider does one quotient bit per cycle over 48 bits
// the first request after reset and requests without pulses skip to finish
// one request at a time: a new request is taken as soon as the previous one has
//   reached the output register
// reset: all history is cleared, the first request after reset only primes the
//   stored count and capture and returns zero; registers return to defaults
// when the receiver stalls the result holds in the output register, and the
//   block keeps its input stalled while the next result waits behind it
module encoder_hybrid_velocity #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ehv_pkg::CNT_W-1:0]      pulse_count_i,
  input  logic [ehv_pkg::CNT_W-1:0]      capture_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [ehv_pkg::VEL_W-1:0] velocity_o,
  input  logic                           cfg_we_i,
  input  logic [ehv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ehv_pkg::CFG_W-1:0]      cfg_data_i
);

  import ehv_pkg::*;

  localparam int FRAME_W = TIMER_WIDTH + STALL_W + 1;
  localparam logic [CNT_W-1:0] CAP_MASK = (TIMER_WIDTH >= CNT_W) ? {CNT_W{1'b1}} :
                                          CNT_W'((64'd1 << TIMER_WIDTH) - 64'd1);

  ehv_state_e state_q, state_d;

  logic [STALL_W-1:0] stall_limit_q;
  logic [CFG_W-1:0]   scale_q;
  logic               first_q;
  logic [CNT_W-1:0]   prior_count_q;
  logic [CNT_W-1:0]   prior_cap_q;
  logic [VEL_W-1:0]   prior_vel_q;
  logic [STALL_W-1:0] stall_q;

  logic [CNT_W-1:0]   delta_q;
  logic [CNT_W-1:0]   cap_q;
  logic [CNT_W-1:0]   count_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PROD_W-1:0]  prod_q;
  logic [VEL_W-1:0]   res_q;
  logic               out_valid_q;
  logic [VEL_W-1:0]   vel_out_q;

  logic               in_accept;
  logic               mul_en;
  logic               div_start;
  logic               sat_en;
  logic               out_load;
  logic               div_done;
  logic [PROD_W-1:0]  quotient;

  logic [CNT_W-1:0]   diff;
  logic [CNT_W-1:0]   cap_m;
  logic [STALL_W-1:0] stall_inc;
  logic               hit_limit;
  logic [STALL_W-1:0] stall_eff;
  logic [FRAME_W-1:0] frame_raw;
  logic               is_compute;
  logic [CNT_W-1:0]   delta_mag;
  logic               neg;
  logic [VEL_W-1:0]   sat_vel;

  // accept-cycle decode
  always_comb begin
    diff       = pulse_count_i - prior_count_q;
    cap_m      = capture_time_i & CAP_MASK;
    stall_inc  = (stall_q == {STALL_W{1'b1}}) ? stall_q : stall_q + STALL_W'(1);
    hit_limit  = (stall_inc >= stall_limit_q);
    stall_eff  = (prior_vel_q == '0) ? '0 : stall_q;
    frame_raw  = ((FRAME_W'(stall_eff) + FRAME_W'(1)) << TIMER_WIDTH)
                 + FRAME_W'(cap_m) - FRAME_W'(prior_cap_q);
    is_compute = !first_q && (diff != '0);
  end

  // magnitude of the signed delta and saturation of the quotient
  always_comb begin
    neg       = delta_q[CNT_W-1];
    delta_mag = neg ? (~delta_q + CNT_W'(1)) : delta_q;
    if (!neg) begin
      sat_vel = (|quotient[PROD_W-1:VEL_W-1]) ? VEL_MAX : quotient[VEL_W-1:0];
    end else if ((|quotient[PROD_W-1:VEL_W]) ||
                 (quotient[VEL_W-1] && (|quotient[VEL_W-2:0]))) begin
      sat_vel = VEL_MIN;
    end else begin
      sat_vel = ~quotient[VEL_W-1:0] + VEL_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = is_compute ? ST_MUL : ST_FINISH;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    mul_en     = 1'b0;
    div_start  = 1'b0;
    sat_en     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_MUL:    mul_en = 1'b1;
      ST_DIV:    div_start = 1'b1;
      ST_WAIT:   ;
      ST_SAT:    sat_en = 1'b1;
      ST_FINISH: out_load = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_limit_q <= '0;
      scale_q       <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STALL_LIMIT:  stall_limit_q <= cfg_data_i[STALL_W-1:0];
        REG_SCALE_FACTOR: scale_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // history kept between requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q       <= 1'b1;
      prior_count_q <= '0;
      prior_cap_q   <= '0;
      prior_vel_q   <= '0;
      stall_q       <= '0;
    end else if (in_accept) begin
      priority if (first_q) begin
        first_q       <= 1'b0;
        prior_count_q <= pulse_count_i;
        prior_cap_q   <= cap_m;
        prior_vel_q   <= '0;
      end else if (diff == '0) begin
        if (hit_limit) begin
          prior_vel_q <= '0;
          stall_q     <= stall_limit_q;
        end else begin
          stall_q     <= stall_inc;
        end
      end else begin
      end
    end else if (sat_en) begin
      prior_count_q <= count_q;
      prior_cap_q   <= cap_q;
      prior_vel_q   <= sat_vel;
      stall_q       <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      delta_q <= diff;
      cap_q   <= cap_m;
      count_q <= pulse_count_i;
      frame_q <= (frame_raw == '0) ? FRAME_W'(1) : frame_raw;
      if (first_q || hit_limit) begin
        res_q <= '0;
      end else begin
        res_q <= prior_vel_q;
      end
    end else if (sat_en) begin
      res_q <= sat_vel;
    end
    if (mul_en) begin
      prod_q <= PROD_W'(delta_mag) * PROD_W'(scale_q);
    end
  end

  ehv_divider #(
    .DIVIDEND_W(PROD_W),
    .DIVISOR_W (FRAME_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (frame_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // output register parts the two channels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vel_out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign velocity_o  = vel_out_q;

endmodule

// ===== rtl/ehv_checker.sv =====
`timescale 1ns / 1ps
`include "encoder_hybrid_velocity_assert.svh"

module ehv_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [ehv_pkg::VEL_W-1:0] velocity_o
);

  import ehv_pkg::*;

  // a request is worked on alone, so the input closes right after acceptance
  `EHV_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of the sequencer, never from the idle state
  `EHV_ASSERT_IMPL(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

  // a held word keeps its value
  `EHV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(velocity_o))

endmodule

bind encoder_hybrid_velocity ehv_checker u_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ehv_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] capture;
  } enc_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CNT_W-1:0]        pulse_count = '0;
  logic [CNT_W-1:0]        capture_time = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VEL_W-1:0] velocity;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  encoder_hybrid_velocity dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pulse_count_i  (pulse_count),
    .capture_time_i (capture_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .velocity_o     (velocity),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // predictor copy of the block registers and history
  logic [STALL_W-1:0]      cfg_stall_limit = '0;
  logic [CFG_W-1:0]        cfg_scale = SCALE_RESET;
  logic                    awaiting_first = 1'b1;
  logic [CNT_W-1:0]        last_count = '0;
  logic [CNT_W-1:0]        last_capture = '0;
  logic signed [VEL_W-1:0] last_velocity = '0;
  logic [STALL_W-1:0]      idle_periods = '0;

  enc_word_t               sample_queue[$];
  logic signed [VEL_W-1:0] velocity_queue[$];
  logic [CNT_W-1:0]        enc_pos = '0;

  logic                    quiet = 1'b0;
  logic [2:0]              in_gap = '0;
  logic [2:0]              out_gap = '0;
  int                      cycles = 0;
  int                      mismatches = 0;
  int                      accepted = 0;
  int                      checked = 0;
  int                      saturated = 0;
  int                      zeros = 0;
  int                      cfg_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [VEL_W-1:0] predict_velocity(logic [CNT_W-1:0] cnt,
                                                               logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0]        diff;
    longint                  delta;
    longint                  frame;
    longint                  quot;
    logic signed [VEL_W-1:0] vel;
    diff  = cnt - last_count;
    delta = longint'($signed(diff));
    if (awaiting_first) begin
      last_count     = cnt;
      last_capture   = cap;
      last_velocity  = '0;
      awaiting_first = 1'b0;
      vel            = '0;
    end else if (diff == '0) begin
      if (idle_periods != 8'hff) idle_periods = idle_periods + 1'b1;
      if (idle_periods >= cfg_stall_limit) begin
        last_velocity = '0;
        idle_periods  = cfg_stall_limit;
        vel           = '0;
      end else begin
        vel = last_velocity;
      end
    end else begin
      if (last_velocity == '0) idle_periods = '0;
      frame = (longint'(idle_periods) + 1) * 65536 - longint'(last_capture) + longint'(cap);
      if (frame == 0) frame = 1;
      quot = (delta * longint'(cfg_scale)) / frame;
      if (quot > 64'sd2147483647) vel = VEL_MAX;
      else if (quot < -64'sd2147483648) vel = VEL_MIN;
      else vel = quot[VEL_W-1:0];
      last_capture  = cap;
      last_velocity = vel;
      last_count    = cnt;
      idle_periods  = '0;
    end
    return vel;
  endfunction

  task automatic report_mismatch(string what, logic [VEL_W-1:0] got, logic [VEL_W-1:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("mismatch: %s: got %0d, want %0d", what, $signed(got), $signed(want));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STALL_LIMIT) cfg_stall_limit = val[STALL_W-1:0];
    else cfg_scale = val;
    cfg_writes++;
  endtask

  task automatic push_sample(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] cap);
    enc_word_t w;
    w.count   = cnt;
    w.capture = cap;
    sample_queue.push_back(w);
  endtask

  // runs of steady motion and standstill, with some jumps and noise mixed in
  task automatic queue_samples(int n);
    int made;
    int kind;
    int len;
    int step;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len  = $urandom_range(3, 12);
        step = $urandom_range(1, 400);
        if ($urandom_range(0, 1)) step = -step;
        repeat (len) begin
          enc_pos = enc_pos + 16'(step + $urandom_range(0, 4));
          push_sample(enc_pos, 16'($urandom));
        end
        made += len;
      end else if (kind <= 7) begin
        len = $urandom_range(1, int'(cfg_stall_limit) + 2);
        if (len > 40 && $urandom_range(0, 3) != 0) len = $urandom_range(1, 40);
        repeat (len) push_sample(enc_pos, 16'($urandom));
        made += len;
      end else if (kind == 8) begin
        enc_pos = 16'($urandom);
        push_sample(enc_pos, 16'($urandom));
        made++;
      end else begin
        enc_pos = enc_pos + ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
        push_sample(enc_pos, 16'($urandom));
        made++;
      end
    end
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || velocity_queue.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin : drive
    enc_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        velocity_queue.push_back(predict_velocity(pulse_count, capture_time));
        accepted++;
      end
      // a stalled word stays put
      if (!in_valid || !in_stall) begin
        if (in_gap != '0) begin
          in_gap   <= in_gap - 1'b1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap   <= 3'($urandom_range(0, 5));
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          nxt          = sample_queue.pop_front();
          in_valid     <= 1'b1;
          pulse_count  <= nxt.count;
          capture_time <= nxt.capture;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin : observe
    logic signed [VEL_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (velocity_queue.size() == 0) begin
          report_mismatch("velocity word with none pending", velocity, '0);
        end else begin
          want = velocity_queue.pop_front();
          if (velocity !== want) report_mismatch("velocity", velocity, want);
        end
        checked++;
        if (velocity == VEL_MAX || velocity == VEL_MIN) saturated++;
        if (velocity == '0) zeros++;
      end
      if (out_gap != '0) begin
        out_gap   <= out_gap - 1'b1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap   <= 3'($urandom_range(0, 5));
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d velocities pending", cycles,
               velocity_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    write_reg(REG_STALL_LIMIT, 32'd3);
    write_reg(REG_SCALE_FACTOR, SCALE_RESET);
    @(negedge clk);
    push_sample(16'h0000, 16'h0000);  // first request only primes
    push_sample(16'h0001, 16'hffff);
    push_sample(16'h0001, 16'hffff);  // standstill, repeat last velocity
    push_sample(16'h0001, 16'hffff);
    push_sample(16'h0001, 16'hffff);  // reaches the stall limit
    push_sample(16'h0001, 16'hffff);  // stays pinned at the limit
    push_sample(16'h8001, 16'h0000);  // most negative delta, frame of one
    push_sample(16'h0000, 16'hffff);  // most positive delta
    push_sample(16'h7fff, 16'h0000);  // positive saturation
    push_sample(16'h7fff, 16'h1234);
    push_sample(16'h8000, 16'h1234);  // stall period folded into the frame
    push_sample(16'h7fff, 16'h0100);
    drain();

    write_reg(REG_STALL_LIMIT, 32'd0);
    write_reg(REG_SCALE_FACTOR, 32'd1);
    @(negedge clk);
    push_sample(16'h7fff, 16'h5555);  // zero limit forces zero at once
    push_sample(16'hffff, 16'haaaa);
    push_sample(16'h7fff, 16'haaaa);
    push_sample(16'h7ffe, 16'h0000);
    push_sample(16'h7ffe, 16'hffff);
    drain();
    enc_pos = 16'h7ffe;

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_STALL_LIMIT, 32'd255);
          write_reg(REG_SCALE_FACTOR, 32'hffff_ffff);
        end
        1: begin
          write_reg(REG_STALL_LIMIT, 32'd1);
          write_reg(REG_SCALE_FACTOR, SCALE_RESET);
        end
        2: begin
          write_reg(REG_STALL_LIMIT, 32'($urandom_range(0, 255)));
          write_reg(REG_SCALE_FACTOR, 32'($urandom_range(1, 100000000)));
        end
        3: begin
          write_reg(REG_STALL_LIMIT, 32'($urandom_range(2, 20)));
          write_reg(REG_SCALE_FACTOR, 32'($urandom_range(1, 1000)));
        end
        default: begin
          write_reg(REG_STALL_LIMIT, 32'd5);
          write_reg(REG_SCALE_FACTOR, 32'($urandom_range(1, 32'hffff_ffff)));
          quiet = 1'b1;
        end
      endcase
      @(negedge clk);
      queue_samples(150);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d encoder requests over %0d register writes, %0d velocities checked",
             accepted, cfg_writes, checked);
    $display("run: %0d saturated and %0d zero velocities seen", saturated, zeros);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
